/* hdl/scp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Super I/O configuration port package
// Shared types, key codes and register offsets of the configuration port.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int unsigned UNIT_SPAN = 256;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	localparam logic [7:0] KEY_ENTER     = 8'h55;
	localparam logic [7:0] KEY_EXIT      = 8'hAA;
	localparam logic [7:0] REG_UNIT_NUM  = 8'h07;
	localparam logic [7:0] REG_BASE_LO   = 8'h26;
	localparam logic [7:0] REG_BASE_HI   = 8'h27;
	localparam logic [7:0] UREG_ACTIVATE = 8'h30;
	localparam logic [7:0] UREG_BASE_HI  = 8'h60;
	localparam logic [7:0] UREG_BASE_LO  = 8'h61;
	localparam logic [7:0] UREG_IRQ      = 8'h70;
	localparam logic [3:0] IRQ_MASK      = 4'hF;

	localparam logic [7:0] PORT_BASE_STD = 8'h2E;
	localparam logic [7:0] PORT_BASE_ALT = 8'h4E;

	localparam logic [7:0] FIRST_SERIAL_UNIT = 8'h04;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic clear_en;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_status_t;

endpackage

/* hdl/scp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// One byte bus access: read or write, index or data port, write byte.
// ----------------------------------------------------------------------------
interface scp_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic       port_select;
	logic [7:0] write_byte;

	modport source (output valid, output opcode, output port_select, output write_byte,
		input ready);
	modport sink (input valid, input opcode, input port_select, input write_byte,
		output ready);
endinterface

/* hdl/scp_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Read byte of one access and the current serial device decode.
// ----------------------------------------------------------------------------
interface scp_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_byte;
	logic        com_a_enabled;
	logic [15:0] com_a_base;
	logic [3:0]  com_a_irq;
	logic        com_b_enabled;
	logic [15:0] com_b_base;
	logic [3:0]  com_b_irq;

	modport source (output valid, output read_byte, output com_a_enabled,
		output com_a_base, output com_a_irq, output com_b_enabled,
		output com_b_base, output com_b_irq, input ready);
	modport sink (input valid, input read_byte, input com_a_enabled,
		input com_a_base, input com_a_irq, input com_b_enabled,
		input com_b_base, input com_b_irq, output ready);
endinterface

/* hdl/scp_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the port base strap.
// ----------------------------------------------------------------------------
interface scp_cfg_if;
	logic valid;
	logic ready;
	logic alternate_base;

	modport source (output valid, output alternate_base, input ready);
	modport sink (input valid, input alternate_base, output ready);
endinterface

/* hdl/scp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/scp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration port controller
// Sequences the clearing pass, request acceptance and response hand-off.
// ----------------------------------------------------------------------------
module scp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  scp_pkg::dp_status_t   status,
	output scp_pkg::ctrl_cmd_t    cmd
);

	scp_pkg::ctrl_state_t state_q;
	scp_pkg::ctrl_state_t state_n;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			scp_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_n = scp_pkg::ST_IDLE;
				end
			end
			scp_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_n = scp_pkg::ST_RESP;
				end
			end
			scp_pkg::ST_RESP: begin
				if (slot_free) begin
					state_n = scp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = scp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd.accept   = 1'b0;
		cmd.clear_en = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			scp_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			scp_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			scp_pkg::ST_RESP: begin
				cmd.load_out = slot_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scp_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	a_accept_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == scp_pkg::ST_RESP)
		else $error("accepted request did not move to response");

	a_no_request_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scp_pkg::ST_CLEAR |-> !req_ready && !cmd.load_out)
		else $error("request path active during clearing pass");

	a_pending_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp_ready |=> out_valid_q)
		else $error("pending response dropped");

endmodule

/* hdl/scp_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration port datapath
// Register memories, mode, index, serial shadows and decode latches.
// ----------------------------------------------------------------------------
module scp_dpath #(
	parameter int unsigned GLOBAL_COUNT = 48,
	parameter int unsigned UNIT_COUNT   = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scp_pkg::ctrl_cmd_t   cmd,
	output scp_pkg::dp_status_t  status,
	input  logic                 opcode,
	input  logic                 port_select,
	input  logic [7:0]           write_byte,
	input  logic                 cfg_write,
	input  logic                 alternate_base,
	output logic [7:0]           read_byte,
	output logic                 com_a_enabled,
	output logic [15:0]          com_a_base,
	output logic [3:0]           com_a_irq,
	output logic                 com_b_enabled,
	output logic [15:0]          com_b_base,
	output logic [3:0]           com_b_irq
);

	localparam int unsigned GW    = $clog2(GLOBAL_COUNT);
	localparam int unsigned UW    = $clog2(UNIT_COUNT);
	localparam int unsigned UDEPTH = UNIT_COUNT * scp_pkg::UNIT_SPAN;
	localparam int unsigned UA    = $clog2(UDEPTH);

	logic                  alt_q;
	logic                  mode_q;
	logic                  rd_req_q;
	logic [7:0]            index_q;
	logic [7:0]            unit_q;
	logic [GLOBAL_COUNT-1:0] gvalid_q;
	logic [UA-1:0]         clr_q;

	logic [7:0]            sh_act_q  [2];
	logic [15:0]           sh_base_q [2];
	logic [3:0]            sh_irq_q  [2];
	logic                  live_q    [2];
	logic [15:0]           base_q    [2];
	logic [3:0]            irq_q     [2];
	logic                  live_n    [2];
	logic [15:0]           base_n    [2];
	logic [3:0]            irq_n     [2];
	logic                  drop      [2];

	logic                  is_write;
	logic                  is_data;
	logic                  key_enter;
	logic                  key_exit;
	logic                  in_global;
	logic                  unit_ok;
	logic                  gwr;
	logic                  uwr;
	logic                  exit_latch;

	logic                  u_we;
	logic [UA-1:0]         u_waddr;
	logic [UA-1:0]         u_addr;
	logic [7:0]            u_wdata;
	logic [7:0]            g_rdata;
	logic [7:0]            u_rdata;
	logic [7:0]            g_reset_val;
	logic [7:0]            rd;

	logic [7:0]            out_read_byte_q;
	logic                  out_live_q [2];
	logic [15:0]           out_base_q [2];
	logic [3:0]            out_irq_q  [2];

	assign is_write  = opcode == scp_pkg::OP_WRITE;
	assign is_data   = port_select == scp_pkg::PORT_DATA;
	assign key_enter = is_write && !is_data && write_byte == scp_pkg::KEY_ENTER;
	assign key_exit  = is_write && !is_data && write_byte == scp_pkg::KEY_EXIT;
	assign in_global = index_q < 8'(GLOBAL_COUNT);
	assign unit_ok   = unit_q < 8'(UNIT_COUNT);

	assign gwr        = cmd.accept && is_write && is_data && mode_q && in_global;
	assign uwr        = cmd.accept && is_write && is_data && mode_q && !in_global && unit_ok;
	assign exit_latch = cmd.accept && key_exit && mode_q;

	assign u_addr  = {unit_q[UW-1:0], index_q};
	assign u_we    = cmd.clear_en || uwr;
	assign u_waddr = cmd.clear_en ? clr_q : u_addr;
	assign u_wdata = cmd.clear_en ? 8'h00 : write_byte;

	assign status.clear_last = clr_q == UA'(UDEPTH - 1);

	scp_ram #(.WIDTH(8), .DEPTH(GLOBAL_COUNT)) u_global_ram (
		.clk   (clk),
		.we    (gwr),
		.waddr (index_q[GW-1:0]),
		.wdata (write_byte),
		.re    (cmd.accept),
		.raddr (index_q[GW-1:0]),
		.rdata (g_rdata)
	);

	scp_ram #(.WIDTH(8), .DEPTH(UDEPTH)) u_unit_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.re    (cmd.accept),
		.raddr (u_addr),
		.rdata (u_rdata)
	);

	// Unwritten global entries read their reset value; the port base follows the strap
	always_comb begin
		g_reset_val = 8'h00;
		if (index_q == scp_pkg::REG_BASE_LO) begin
			g_reset_val = alt_q ? scp_pkg::PORT_BASE_ALT : scp_pkg::PORT_BASE_STD;
		end
	end

	// Read requests leave mode, index and unit untouched, so decode from live state;
	// hold the access kind from acceptance
	always_comb begin
		rd = 8'h00;
		if (mode_q && rd_req_q) begin
			if (in_global) begin
				rd = gvalid_q[index_q[GW-1:0]] ? g_rdata : g_reset_val;
			end else if (unit_ok) begin
				rd = u_rdata;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			live_n[i] = live_q[i];
			base_n[i] = base_q[i];
			irq_n[i]  = irq_q[i];
			drop[i]   = sh_act_q[i] == 8'h00 || base_q[i] != sh_base_q[i] ||
				irq_q[i] != sh_irq_q[i];
			if (exit_latch) begin
				if (live_q[i] && drop[i]) begin
					live_n[i] = 1'b0;
				end
				if (!(live_q[i] && !drop[i]) && sh_act_q[i] != 8'h00) begin
					base_n[i] = sh_base_q[i];
					irq_n[i]  = sh_irq_q[i];
					live_n[i] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q    <= 1'b0;
			mode_q   <= 1'b0;
			rd_req_q <= 1'b0;
			index_q  <= 8'h00;
			unit_q   <= 8'h00;
			gvalid_q <= '0;
			clr_q    <= '0;
			for (int i = 0; i < 2; i++) begin
				sh_act_q[i]  <= 8'h00;
				sh_base_q[i] <= 16'h0000;
				sh_irq_q[i]  <= 4'h0;
				live_q[i]    <= 1'b0;
				base_q[i]    <= 16'h0000;
				irq_q[i]     <= 4'h0;
			end
		end else begin
			if (cmd.clear_en && !status.clear_last) begin
				clr_q <= clr_q + UA'(1);
			end
			// Strap change reloads the port base bytes
			if (cfg_write) begin
				alt_q <= alternate_base;
				gvalid_q[GW'(scp_pkg::REG_BASE_LO)] <= 1'b0;
				gvalid_q[GW'(scp_pkg::REG_BASE_HI)] <= 1'b0;
			end
			if (cmd.accept) begin
				rd_req_q <= !is_write && is_data;
				if (key_enter) begin
					mode_q <= 1'b1;
				end else if (key_exit) begin
					mode_q <= 1'b0;
				end else if (is_write && !is_data && mode_q) begin
					index_q <= write_byte;
				end
			end
			if (gwr) begin
				gvalid_q[index_q[GW-1:0]] <= 1'b1;
				if (index_q == scp_pkg::REG_UNIT_NUM) begin
					unit_q <= write_byte;
				end
			end
			for (int i = 0; i < 2; i++) begin
				if (uwr && unit_q == scp_pkg::FIRST_SERIAL_UNIT + 8'(i)) begin
					if (index_q == scp_pkg::UREG_ACTIVATE) begin
						sh_act_q[i] <= write_byte;
					end
					if (index_q == scp_pkg::UREG_BASE_HI) begin
						sh_base_q[i][15:8] <= write_byte;
					end
					if (index_q == scp_pkg::UREG_BASE_LO) begin
						sh_base_q[i][7:0] <= write_byte;
					end
					if (index_q == scp_pkg::UREG_IRQ) begin
						sh_irq_q[i] <= write_byte[3:0] & scp_pkg::IRQ_MASK;
					end
				end
				live_q[i] <= live_n[i];
				base_q[i] <= base_n[i];
				irq_q[i]  <= irq_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_read_byte_q <= rd;
			for (int i = 0; i < 2; i++) begin
				out_live_q[i] <= live_q[i];
				out_base_q[i] <= base_q[i];
				out_irq_q[i]  <= irq_q[i];
			end
		end
	end

	assign read_byte     = out_read_byte_q;
	assign com_a_enabled = out_live_q[0];
	assign com_a_base    = out_base_q[0];
	assign com_a_irq     = out_irq_q[0];
	assign com_b_enabled = out_live_q[1];
	assign com_b_base    = out_base_q[1];
	assign com_b_irq     = out_irq_q[1];

	a_exit_clears_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && key_exit |=> !mode_q)
		else $error("exit key left configuration mode set");

	a_latch_only_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		!exit_latch |=> $stable(live_q[0]) && $stable(live_q[1]) &&
			$stable(base_q[0]) && $stable(base_q[1]))
		else $error("serial decode changed without exit key");

	a_clear_excludes_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_en && (cmd.accept || cmd.load_out)))
		else $error("access during clearing pass");

endmodule

/* hdl/superio_config_port_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Super I/O configuration port
// Index/data configuration port with two serial logical device decodes.
// ----------------------------------------------------------------------------
// Each request is one byte access to the index/key port or the data port and
// yields exactly one response. A request is accepted in the idle state and its
// response is registered in the response state once the output register is free,
// from the registered read of the register memories; the next request is taken once
// the response is in the output register, even while it still waits to be
// taken. After reset the logical device memory is cleared one entry a cycle,
// all UNIT_COUNT * 256 entries (3072 by default), before the first request is
// accepted; configuration writes are taken at any time and are always ready.
module superio_config_port_unit #(
	parameter int unsigned GLOBAL_COUNT = 48,
	parameter int unsigned UNIT_COUNT   = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	scp_cfg_if.sink   cfg,
	scp_req_if.sink   req,
	scp_rsp_if.source rsp
);

	scp_pkg::ctrl_cmd_t  cmd;
	scp_pkg::dp_status_t status;
	logic                cfg_write;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;

	scp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	scp_dpath #(
		.GLOBAL_COUNT (GLOBAL_COUNT),
		.UNIT_COUNT   (UNIT_COUNT)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (req.opcode),
		.port_select    (req.port_select),
		.write_byte     (req.write_byte),
		.cfg_write      (cfg_write),
		.alternate_base (cfg.alternate_base),
		.read_byte      (rsp.read_byte),
		.com_a_enabled  (rsp.com_a_enabled),
		.com_a_base     (rsp.com_a_base),
		.com_a_irq      (rsp.com_a_irq),
		.com_b_enabled  (rsp.com_b_enabled),
		.com_b_base     (rsp.com_b_base),
		.com_b_irq      (rsp.com_b_irq)
	);

endmodule
